// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/lnpe_pkg.sv =====
// shared types, codes and constants of the line-program encoder
// no dependencies
package lnpe_pkg;

    // width of the leb128 shift register (34-bit signed line delta plus margin)
    localparam int unsigned LEB_W = 35;

    // input item selector
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_NEXT  = 2'd1;
    localparam logic [1:0] FUNC_END   = 2'd2;
    localparam logic [1:0] FUNC_BAD   = 2'd3;

    // standard and extended opcodes
    localparam logic [7:0] OP_EXTENDED     = 8'd0;
    localparam logic [7:0] OP_COPY         = 8'd1;
    localparam logic [7:0] OP_ADVANCE_PC   = 8'd2;
    localparam logic [7:0] OP_ADVANCE_LINE = 8'd3;
    localparam logic [7:0] OP_SET_FILE     = 8'd4;
    localparam logic [7:0] OP_SET_COLUMN   = 8'd5;
    localparam logic [7:0] OP_NEGATE_STMT  = 8'd6;
    localparam logic [7:0] EXT_END_SEQ     = 8'd1;
    localparam logic [7:0] EXT_SET_ADDR    = 8'd2;
    localparam logic [7:0] EXT_LEN_ADDR    = 8'd9;
    localparam logic [7:0] EXT_LEN_END     = 8'd1;
    localparam logic [7:0] ERR_BYTE        = 8'd0;

    // output byte source
    localparam logic [1:0] BSEL_CONST = 2'd0;
    localparam logic [1:0] BSEL_LEB   = 2'd1;
    localparam logic [1:0] BSEL_ADDR  = 2'd2;

    // leb128 load source
    localparam logic [1:0] LD_FILE  = 2'd0;
    localparam logic [1:0] LD_COL   = 2'd1;
    localparam logic [1:0] LD_LINE  = 2'd2;
    localparam logic [1:0] LD_DELTA = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic       capture;
        logic       check;
        logic       emit;
        logic [1:0] byte_sel;
        logic [7:0] const_byte;
        logic       last;
        logic       error;
        logic       leb_load;
        logic [1:0] leb_sel;
        logic       leb_shift;
        logic       addr_shift;
    } lnpe_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic       out_free;
        logic       err;
        logic       leb_done;
        logic [1:0] func;
        logic       file_chg;
        logic       line_chg;
        logic       col_chg;
        logic       stmt_chg;
    } lnpe_status_t;

endpackage

// ===== src/lnpe_regs.sv =====
// configuration registers behind the apb-style port
// no package dependencies
module lnpe_regs (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output logic [63:0] base_address,
    output logic [31:0] text_size
);

    // register index taken from address bit 3 (8-byte spacing)
    localparam logic REG_BASE = 1'b0;
    localparam logic REG_TEXT = 1'b1;

    logic [63:0] base_reg;
    logic [31:0] text_reg;
    logic        wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= 64'd0;
            text_reg <= 32'hFFFF_FFFF;
        end else if (wr) begin
            if (paddr[3] == REG_BASE) begin
                base_reg <= pwdata;
            end else begin
                text_reg <= pwdata[31:0];
            end
        end
    end

    // read back
    assign prdata = (paddr[3] == REG_TEXT) ? {32'd0, text_reg} : base_reg;

    assign base_address = base_reg;
    assign text_size    = text_reg;

endmodule

// ===== src/lnpe_datapath.sv =====
// datapath: item capture, checks, sequence state, leb128 and address shifters,
// output register; depends on lnpe_pkg
module lnpe_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lnpe_pkg::lnpe_cmd_t   cmd,
    output lnpe_pkg::lnpe_status_t st,
    input  logic [63:0]           base_address,
    input  logic [31:0]           text_size,
    input  logic [1:0]            s_func,
    input  logic [31:0]           s_code_offset,
    input  logic [31:0]           s_file_number,
    input  logic [31:0]           s_line_number,
    input  logic [31:0]           s_column_number,
    input  logic                  s_is_statement,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_last,
    output logic                  m_error
);
    import lnpe_pkg::*;

    // captured item
    logic [1:0]  func_reg;
    logic [31:0] off_reg, file_reg, line_reg, col_reg;
    logic        stmt_reg;

    // sequence state
    logic [31:0] prev_off_reg, prev_file_reg, prev_line_reg, prev_col_reg;
    logic        prev_stmt_reg;

    // values worked out at the check cycle
    logic [63:0]      addr_reg;
    logic [31:0]      delta_reg;
    logic [LEB_W-1:0] linev_reg;
    logic             file_chg_reg, line_chg_reg, col_chg_reg, stmt_chg_reg;

    // leb128 shifter
    logic [LEB_W-1:0] leb_reg, leb_next;
    logic             sleb_reg;

    // output register
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg, error_reg;

    logic [64:0]      sum;
    logic             off_gt_prev;
    logic             err;
    logic [32:0]      line_m1;
    logic [33:0]      line_diff;
    logic [LEB_W-1:0] linev_next;
    logic [LEB_W-1:0] leb_rest;
    logic             leb_more;
    logic [7:0]       byte_next;

    // item capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg <= s_func;
            off_reg  <= s_code_offset;
            file_reg <= s_file_number;
            line_reg <= s_line_number;
            col_reg  <= s_column_number;
            stmt_reg <= s_is_statement;
        end
    end

    // item checks
    always_comb begin
        sum         = {1'b0, base_address} + {33'd0, off_reg};
        off_gt_prev = off_reg > prev_off_reg;
        case (func_reg)
            FUNC_START: err = (off_reg > text_size) || (file_reg == 32'd0) || sum[64];
            FUNC_NEXT:  err = !off_gt_prev || (file_reg == 32'd0);
            FUNC_END:   err = !off_gt_prev;
            FUNC_BAD:   err = 1'b1;
            default:    err = 1'b1;
        endcase
    end

    // line value: line minus one at start, difference to previous line otherwise
    always_comb begin
        line_m1   = {1'b0, line_reg} - 33'd1;
        line_diff = {2'b00, line_reg} - {2'b00, prev_line_reg};
        if (func_reg == FUNC_START) begin
            linev_next = {{(LEB_W-33){line_m1[32]}}, line_m1};
        end else begin
            linev_next = {{(LEB_W-34){line_diff[33]}}, line_diff};
        end
    end

    // check cycle: latch derived values
    always_ff @(posedge aclk) begin
        if (cmd.check) begin
            addr_reg     <= sum[63:0];
            delta_reg    <= off_reg - prev_off_reg;
            linev_reg    <= linev_next;
            file_chg_reg <= file_reg != prev_file_reg;
            line_chg_reg <= line_reg != prev_line_reg;
            col_chg_reg  <= col_reg != prev_col_reg;
            stmt_chg_reg <= (func_reg == FUNC_START) ? !stmt_reg
                                                     : (stmt_reg != prev_stmt_reg);
        end else if (cmd.addr_shift) begin
            addr_reg <= {8'd0, addr_reg[63:8]};
        end
    end

    // sequence state update for accepted start and next items
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_off_reg  <= 32'd0;
            prev_file_reg <= 32'd0;
            prev_line_reg <= 32'd0;
            prev_col_reg  <= 32'd0;
            prev_stmt_reg <= 1'b1;
        end else if (cmd.check && !err && (func_reg != FUNC_END)) begin
            prev_off_reg  <= off_reg;
            prev_file_reg <= file_reg;
            prev_line_reg <= line_reg;
            prev_col_reg  <= col_reg;
            prev_stmt_reg <= stmt_reg;
        end
    end

    // leb128 digit and continuation
    always_comb begin
        leb_rest = {{7{leb_reg[LEB_W-1]}}, leb_reg[LEB_W-1:7]};
        if (sleb_reg) begin
            leb_more = !(((leb_rest == '0) && !leb_reg[6]) ||
                         ((leb_rest == '1) && leb_reg[6]));
        end else begin
            leb_more = leb_rest != '0;
        end
    end

    // leb128 load source
    always_comb begin
        case (cmd.leb_sel)
            LD_FILE:  leb_next = {{(LEB_W-32){1'b0}}, file_reg - 32'd1};
            LD_COL:   leb_next = {{(LEB_W-32){1'b0}}, col_reg};
            LD_LINE:  leb_next = linev_reg;
            LD_DELTA: leb_next = {{(LEB_W-32){1'b0}}, delta_reg};
            default:  leb_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.leb_load) begin
            leb_reg  <= leb_next;
            sleb_reg <= cmd.leb_sel == LD_LINE;
        end else if (cmd.leb_shift) begin
            leb_reg <= leb_rest;
        end
    end

    // output byte select
    always_comb begin
        case (cmd.byte_sel)
            BSEL_CONST: byte_next = cmd.const_byte;
            BSEL_LEB:   byte_next = {leb_more, leb_reg[6:0]};
            BSEL_ADDR:  byte_next = addr_reg[7:0];
            default:    byte_next = cmd.const_byte;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            byte_reg  <= byte_next;
            last_reg  <= cmd.last;
            error_reg <= cmd.error;
        end
    end

    assign m_valid    = valid_reg;
    assign m_out_byte = byte_reg;
    assign m_last     = last_reg;
    assign m_error    = error_reg;

    // status back to the controller
    assign st.out_free = !valid_reg || m_ready;
    assign st.err      = err;
    assign st.leb_done = !leb_more;
    assign st.func     = func_reg;
    assign st.file_chg = file_chg_reg;
    assign st.line_chg = line_chg_reg;
    assign st.col_chg  = col_chg_reg;
    assign st.stmt_chg = stmt_chg_reg;

endmodule

// ===== src/lnpe_ctrl.sv =====
// controller: steps through the opcode sequence of each item, one beat a cycle while
// the output register is free; depends on lnpe_pkg
module lnpe_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  lnpe_pkg::lnpe_status_t st,
    output lnpe_pkg::lnpe_cmd_t    cmd
);
    import lnpe_pkg::*;

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_CHECK    = 5'd1;
    localparam logic [4:0] ST_ERR      = 5'd2;
    localparam logic [4:0] ST_FILE_OP  = 5'd3;
    localparam logic [4:0] ST_FILE_LEB = 5'd4;
    localparam logic [4:0] ST_COL_OP   = 5'd5;
    localparam logic [4:0] ST_COL_LEB  = 5'd6;
    localparam logic [4:0] ST_LINE_OP  = 5'd7;
    localparam logic [4:0] ST_LINE_LEB = 5'd8;
    localparam logic [4:0] ST_NEG      = 5'd9;
    localparam logic [4:0] ST_EXT0     = 5'd10;
    localparam logic [4:0] ST_EXT_LEN  = 5'd11;
    localparam logic [4:0] ST_EXT_OP   = 5'd12;
    localparam logic [4:0] ST_ADDR     = 5'd13;
    localparam logic [4:0] ST_COPY     = 5'd14;
    localparam logic [4:0] ST_PC_OP    = 5'd15;
    localparam logic [4:0] ST_PC_LEB   = 5'd16;

    logic [4:0] state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       is_start, is_end;
    logic       leb_step;

    assign is_start = st.func == FUNC_START;
    assign is_end   = st.func == FUNC_END;
    assign leb_step = st.out_free && st.leb_done;
    assign s_ready  = state_reg == ST_IDLE;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        cmd.byte_sel   = BSEL_CONST;
        cmd.const_byte = OP_COPY;
        cmd.leb_sel    = LD_FILE;
        case (state_reg)
            ST_IDLE: begin
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            // checks and derived values, no beat
            ST_CHECK: begin
                cmd.check = 1'b1;
                if (st.err) begin
                    state_next = ST_ERR;
                end else if (is_start) begin
                    state_next = ST_FILE_OP;
                end else begin
                    state_next = ST_PC_OP;
                end
            end
            ST_ERR: begin
                cmd.emit       = st.out_free;
                cmd.const_byte = ERR_BYTE;
                cmd.last       = 1'b1;
                cmd.error      = 1'b1;
                if (st.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FILE_OP: begin
                cmd.emit       = st.out_free;
                cmd.const_byte = OP_SET_FILE;
                cmd.leb_load   = st.out_free;
                cmd.leb_sel    = LD_FILE;
                if (st.out_free) begin
                    state_next = ST_FILE_LEB;
                end
            end
            ST_FILE_LEB: begin
                cmd.emit      = st.out_free;
                cmd.byte_sel  = BSEL_LEB;
                cmd.leb_shift = st.out_free;
                if (leb_step) begin
                    if (is_start || st.line_chg) begin
                        state_next = is_start ? ST_COL_OP : ST_LINE_OP;
                    end else if (st.col_chg) begin
                        state_next = ST_COL_OP;
                    end else if (st.stmt_chg) begin
                        state_next = ST_NEG;
                    end else begin
                        state_next = ST_COPY;
                    end
                end
            end
            ST_COL_OP: begin
                cmd.emit       = st.out_free;
                cmd.const_byte = OP_SET_COLUMN;
                cmd.leb_load   = st.out_free;
                cmd.leb_sel    = LD_COL;
                if (st.out_free) begin
                    state_next = ST_COL_LEB;
                end
            end
            ST_COL_LEB: begin
                cmd.emit      = st.out_free;
                cmd.byte_sel  = BSEL_LEB;
                cmd.leb_shift = st.out_free;
                if (leb_step) begin
                    if (is_start) begin
                        state_next = ST_LINE_OP;
                    end else if (st.stmt_chg) begin
                        state_next = ST_NEG;
                    end else begin
                        state_next = ST_COPY;
                    end
                end
            end
            ST_LINE_OP: begin
                cmd.emit       = st.out_free;
                cmd.const_byte = OP_ADVANCE_LINE;
                cmd.leb_load   = st.out_free;
                cmd.leb_sel    = LD_LINE;
                if (st.out_free) begin
                    state_next = ST_LINE_LEB;
                end
            end
            ST_LINE_LEB: begin
                cmd.emit      = st.out_free;
                cmd.byte_sel  = BSEL_LEB;
                cmd.leb_shift = st.out_free;
                if (leb_step) begin
                    if (is_start) begin
                        state_next = st.stmt_chg ? ST_NEG : ST_EXT0;
                    end else if (st.col_chg) begin
                        state_next = ST_COL_OP;
                    end else if (st.stmt_chg) begin
                        state_next = ST_NEG;
                    end else begin
                        state_next = ST_COPY;
                    end
                end
            end
            ST_NEG: begin
                cmd.emit       = st.out_free;
                cmd.const_byte = OP_NEGATE_STMT;
                if (st.out_free) begin
                    state_next = is_start ? ST_EXT0 : ST_COPY;
                end
            end
            ST_EXT0: begin
                cmd.emit       = st.out_free;
                cmd.const_byte = OP_EXTENDED;
                if (st.out_free) begin
                    state_next = ST_EXT_LEN;
                end
            end
            ST_EXT_LEN: begin
                cmd.emit       = st.out_free;
                cmd.const_byte = is_start ? EXT_LEN_ADDR : EXT_LEN_END;
                if (st.out_free) begin
                    state_next = ST_EXT_OP;
                end
            end
            ST_EXT_OP: begin
                cmd.emit       = st.out_free;
                cmd.const_byte = is_start ? EXT_SET_ADDR : EXT_END_SEQ;
                cmd.last       = is_end;
                cnt_next       = 3'd0;
                if (st.out_free) begin
                    state_next = is_start ? ST_ADDR : ST_IDLE;
                end
            end
            // eight address bytes, little-endian
            ST_ADDR: begin
                cmd.emit       = st.out_free;
                cmd.byte_sel   = BSEL_ADDR;
                cmd.addr_shift = st.out_free;
                if (st.out_free) begin
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7) begin
                        state_next = ST_COPY;
                    end
                end
            end
            ST_COPY: begin
                cmd.emit       = st.out_free;
                cmd.const_byte = OP_COPY;
                cmd.last       = 1'b1;
                if (st.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_PC_OP: begin
                cmd.emit       = st.out_free;
                cmd.const_byte = OP_ADVANCE_PC;
                cmd.leb_load   = st.out_free;
                cmd.leb_sel    = LD_DELTA;
                if (st.out_free) begin
                    state_next = ST_PC_LEB;
                end
            end
            ST_PC_LEB: begin
                cmd.emit      = st.out_free;
                cmd.byte_sel  = BSEL_LEB;
                cmd.leb_shift = st.out_free;
                if (leb_step) begin
                    if (is_end) begin
                        state_next = ST_EXT0;
                    end else if (st.file_chg) begin
                        state_next = ST_FILE_OP;
                    end else if (st.line_chg) begin
                        state_next = ST_LINE_OP;
                    end else if (st.col_chg) begin
                        state_next = ST_COL_OP;
                    end else if (st.stmt_chg) begin
                        state_next = ST_NEG;
                    end else begin
                        state_next = ST_COPY;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 3'd0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== src/line_number_program_encoder.sv =====
// Line-program encoder: an item producing n beats (1 to 31) occupies the block
// through the accept state and the check state, then one beat a cycle
// from the controller into the output register; a stalled output stretches this.
// The first beat follows the check state, once the output register is free.
// Reset (aresetn low, synchronous) clears the controller, output valid, the
// sequence state (previous values zero, statement flag one) and base address.
module line_number_program_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [31:0] s_code_offset,
    input  logic [31:0] s_file_number,
    input  logic [31:0] s_line_number,
    input  logic [31:0] s_column_number,
    input  logic        s_is_statement,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last,
    output logic        m_error,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import lnpe_pkg::*;

    lnpe_cmd_t    cmd;
    lnpe_status_t st;
    logic [63:0]  base_address;
    logic [31:0]  text_size;

    // configuration registers
    lnpe_regs u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .base_address (base_address),
        .text_size    (text_size)
    );

    // sequencing
    lnpe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // datapath
    lnpe_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .st              (st),
        .base_address    (base_address),
        .text_size       (text_size),
        .s_func          (s_func),
        .s_code_offset   (s_code_offset),
        .s_file_number   (s_file_number),
        .s_line_number   (s_line_number),
        .s_column_number (s_column_number),
        .s_is_statement  (s_is_statement),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_last          (m_last),
        .m_error         (m_error)
    );

endmodule

// ===== src/lnpe_checker.sv =====
// port-level checks of the line-program encoder, bound to the top level
// depends on assert_macros.svh and line_number_program_encoder
`include "assert_macros.svh"

module lnpe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_func,
    input logic [31:0] s_code_offset,
    input logic [31:0] s_file_number,
    input logic [31:0] s_line_number,
    input logic [31:0] s_column_number,
    input logic        s_is_statement,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_byte,
    input logic        m_last,
    input logic        m_error,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [63:0] pwdata,
    input logic [63:0] prdata,
    input logic        pready
);

    // a rejected item gives a single zero beat marked last
    `ASSERT_CLK(a_err_beat, aclk, aresetn, m_valid && m_error |-> m_last && (m_out_byte == 8'd0), "error beat not zero or not last")

    // one item at a time: input closes right after a beat is taken in
    `ASSERT_CLK(a_one_item, aclk, aresetn, s_valid && s_ready |=> !s_ready, "input accepted while item in progress")

    // a stalled result beat holds
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last), "stalled result beat changed")

    // register port never waits
    `ASSERT_ALWAYS(a_pready, aclk, pready, "pready low")

endmodule

bind line_number_program_encoder lnpe_checker u_lnpe_checker (.*);

// ===== bench/tb_line_number_program_encoder.sv =====
// testbench for the line-program encoder: directed and random location records
// checked beat by beat against a predictor of the encoded byte stream
// depends on lnpe_pkg and line_number_program_encoder
module tb_line_number_program_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import lnpe_pkg::*;

    localparam logic [3:0] ADDR_BASE      = 4'd0;
    localparam logic [3:0] ADDR_TEXT_SIZE = 4'd8;
    localparam int         LIMIT_CYCLES   = 400000;

    // one beat of the line program as the block should send it
    typedef struct packed {
        logic [7:0] data;
        logic       last_flag;
        logic       err_flag;
    } prog_beat_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_func;
    logic [31:0] s_code_offset;
    logic [31:0] s_file_number;
    logic [31:0] s_line_number;
    logic [31:0] s_column_number;
    logic        s_is_statement;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_byte;
    logic        m_last;
    logic        m_error;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    // predictor copy of registers and sequence state
    logic [63:0] cfg_base;
    logic [31:0] cfg_text_size;
    logic [31:0] seq_offset;
    logic [31:0] seq_file;
    logic [31:0] seq_line;
    logic [31:0] seq_column;
    logic        seq_stmt;

    prog_beat_t  pending_beats[$];
    logic [7:0]  item_bytes[$];
    int          mismatch_count;
    int          items_sent;
    int          idle_pct;
    int          cycle_count;

    line_number_program_encoder dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_code_offset   (s_code_offset),
        .s_file_number   (s_file_number),
        .s_line_number   (s_line_number),
        .s_column_number (s_column_number),
        .s_is_statement  (s_is_statement),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_last          (m_last),
        .m_error         (m_error),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // clock
    always #4 aclk = ~aclk;

    // cycle limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        m_ready = ($urandom_range(0, 99) >= idle_pct);
    end

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("mismatch at cycle %0d: %s expected %0h got %0h",
                 cycle_count, what, want, got);
        mismatch_count++;
    endtask

    // compare each accepted beat with the oldest expected one
    always @(posedge aclk) begin
        prog_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_beats.size() == 0) begin
                report_mismatch("unexpected beat", 64'd0,
                                {54'd0, m_out_byte, m_last, m_error});
            end else begin
                want = pending_beats.pop_front();
                if (m_out_byte !== want.data)
                    report_mismatch("out_byte", {56'd0, want.data}, {56'd0, m_out_byte});
                if (m_last !== want.last_flag)
                    report_mismatch("last", {63'd0, want.last_flag}, {63'd0, m_last});
                if (m_error !== want.err_flag)
                    report_mismatch("error", {63'd0, want.err_flag}, {63'd0, m_error});
            end
        end
    end

    // unsigned leb128
    function automatic void push_uleb(input logic [63:0] v);
        logic [7:0] b;
        do begin
            b = {1'b0, v[6:0]};
            v = v >> 7;
            if (v != 0)
                b[7] = 1'b1;
            item_bytes.push_back(b);
        end while (v != 0);
    endfunction

    // signed leb128 of a two's complement value
    function automatic void push_sleb(input logic signed [63:0] v);
        logic [7:0] b;
        bit         sgn;
        bit         more;
        more = 1'b1;
        while (more) begin
            b   = {1'b0, v[6:0]};
            sgn = v[6];
            v   = v >>> 7;
            more = !((v == 0 && !sgn) || ((&v) && sgn));
            if (more)
                b[7] = 1'b1;
            item_bytes.push_back(b);
        end
    endfunction

    // expected line-program bytes for one accepted location record
    function automatic void encode_location(input logic [1:0] func, input logic [31:0] off,
                                            input logic [31:0] file, input logic [31:0] line,
                                            input logic [31:0] col, input logic stmt);
        logic [64:0] addr;
        bit          rejected;
        rejected = 1'b0;
        item_bytes.delete();
        addr = {1'b0, cfg_base} + {33'd0, off};
        case (func)
            FUNC_START: begin
                if (off > cfg_text_size || file == 0 || addr[64]) begin
                    rejected = 1'b1;
                end else begin
                    item_bytes.push_back(OP_SET_FILE);
                    push_uleb({32'd0, file} - 64'd1);
                    item_bytes.push_back(OP_SET_COLUMN);
                    push_uleb({32'd0, col});
                    item_bytes.push_back(OP_ADVANCE_LINE);
                    push_sleb({32'd0, line} - 64'd1);
                    if (!stmt)
                        item_bytes.push_back(OP_NEGATE_STMT);
                    item_bytes.push_back(OP_EXTENDED);
                    item_bytes.push_back(EXT_LEN_ADDR);
                    item_bytes.push_back(EXT_SET_ADDR);
                    for (int i = 0; i < 8; i++)
                        item_bytes.push_back(addr[8*i +: 8]);
                    item_bytes.push_back(OP_COPY);
                end
            end
            FUNC_NEXT: begin
                if (off <= seq_offset || file == 0) begin
                    rejected = 1'b1;
                end else begin
                    item_bytes.push_back(OP_ADVANCE_PC);
                    push_uleb({32'd0, off - seq_offset});
                    if (file != seq_file) begin
                        item_bytes.push_back(OP_SET_FILE);
                        push_uleb({32'd0, file} - 64'd1);
                    end
                    if (line != seq_line) begin
                        item_bytes.push_back(OP_ADVANCE_LINE);
                        push_sleb({32'd0, line} - {32'd0, seq_line});
                    end
                    if (col != seq_column) begin
                        item_bytes.push_back(OP_SET_COLUMN);
                        push_uleb({32'd0, col});
                    end
                    if (stmt != seq_stmt)
                        item_bytes.push_back(OP_NEGATE_STMT);
                    item_bytes.push_back(OP_COPY);
                end
            end
            FUNC_END: begin
                if (off <= seq_offset) begin
                    rejected = 1'b1;
                end else begin
                    item_bytes.push_back(OP_ADVANCE_PC);
                    push_uleb({32'd0, off - seq_offset});
                    item_bytes.push_back(OP_EXTENDED);
                    item_bytes.push_back(EXT_LEN_END);
                    item_bytes.push_back(EXT_END_SEQ);
                end
            end
            default: rejected = 1'b1;
        endcase

        if (rejected) begin
            pending_beats.push_back('{data: ERR_BYTE, last_flag: 1'b1, err_flag: 1'b1});
        end else begin
            // end items leave the sequence state alone
            if (func != FUNC_END) begin
                seq_offset = off;
                seq_file   = file;
                seq_line   = line;
                seq_column = col;
                seq_stmt   = stmt;
            end
            foreach (item_bytes[k])
                pending_beats.push_back('{data: item_bytes[k],
                                          last_flag: (k == item_bytes.size() - 1),
                                          err_flag: 1'b0});
        end
    endfunction

    // send one location beat, sometimes with a random gap ahead of it
    task automatic send_location(input logic [1:0] func, input logic [31:0] off,
                                 input logic [31:0] file, input logic [31:0] line,
                                 input logic [31:0] col, input logic stmt);
        @(negedge aclk);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_func          = func;
        s_code_offset   = off;
        s_file_number   = file;
        s_line_number   = line;
        s_column_number = col;
        s_is_statement  = stmt;
        do @(posedge aclk); while (!s_ready);
        encode_location(func, off, file, line, col, stmt);
        items_sent++;
    endtask

    // drop valid and let every expected beat arrive
    task automatic drain_program();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // register write while idle, then read back
    task automatic write_register(input logic [3:0] addr, input logic [63:0] value);
        logic [63:0] mask;
        mask = (addr == ADDR_TEXT_SIZE) ? 64'h0000_0000_FFFF_FFFF : '1;
        drain_program();
        @(negedge aclk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_BASE)
            cfg_base = value;
        else
            cfg_text_size = value[31:0];
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        @(negedge aclk);
        psel = 1'b1;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if ((prdata & mask) !== (value & mask))
            report_mismatch("register read", value & mask, prdata & mask);
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0;
    endtask

    // next and end records against the reset state
    task automatic test_without_start();
        write_register(ADDR_BASE, 64'd0);
        write_register(ADDR_TEXT_SIZE, 64'hFFFF_FFFF);
        send_location(FUNC_NEXT, 32'd5, 32'd1, 32'd1, 32'd1, 1'b1);
        send_location(FUNC_END, 32'd5, 32'd0, 32'd0, 32'd0, 1'b0);
        send_location(FUNC_END, 32'd9, 32'd7, 32'd7, 32'd7, 1'b0);
    endtask

    // short sequence around the leb128 byte boundaries
    task automatic test_sequence_basics();
        send_location(FUNC_START, 32'd0, 32'd1, 32'd1, 32'd0, 1'b1);
        send_location(FUNC_NEXT, 32'd1, 32'd1, 32'd1, 32'd0, 1'b1);
        send_location(FUNC_NEXT, 32'd129, 32'd2, 32'd65, 32'd128, 1'b0);
        send_location(FUNC_NEXT, 32'd130, 32'd2, 32'd1, 32'd128, 1'b1);
        send_location(FUNC_NEXT, 32'd131, 32'd2, 32'd0, 32'd128, 1'b1);
        send_location(FUNC_END, 32'd200, 32'd0, 32'd0, 32'd0, 1'b1);
    endtask

    // all-ones and all-zeros fields
    task automatic test_field_extremes();
        send_location(FUNC_START, '1, '1, 32'd0, '1, 1'b0);
        send_location(FUNC_NEXT, '1, 32'd1, 32'd1, 32'd1, 1'b1);
        send_location(FUNC_START, 32'd0, 32'd1, '1, 32'd0, 1'b1);
        send_location(FUNC_NEXT, '1, '1, 32'd0, '1, 1'b0);
        send_location(FUNC_END, '1, '1, '1, '1, 1'b1);
    endtask

    // zero file, offsets that do not increase, bad selector
    task automatic test_rejections();
        send_location(FUNC_START, 32'd10, 32'd0, 32'd7, 32'd2, 1'b1);
        send_location(FUNC_START, 32'd10, 32'd3, 32'd7, 32'd2, 1'b1);
        send_location(FUNC_NEXT, 32'd20, 32'd0, 32'd8, 32'd2, 1'b1);
        send_location(FUNC_NEXT, 32'd10, 32'd3, 32'd8, 32'd2, 1'b1);
        send_location(FUNC_BAD, 32'd30, 32'd3, 32'd8, 32'd2, 1'b1);
        send_location(FUNC_END, 32'd10, 32'd3, 32'd8, 32'd2, 1'b1);
    endtask

    // address overflow and text size bounds
    task automatic test_address_limits();
        write_register(ADDR_BASE, 64'hFFFF_FFFF_FFFF_FF00);
        write_register(ADDR_TEXT_SIZE, 64'h1000);
        send_location(FUNC_START, 32'hFF, 32'd2, 32'd3, 32'd4, 1'b1);
        send_location(FUNC_START, 32'h100, 32'd2, 32'd3, 32'd4, 1'b1);
        write_register(ADDR_BASE, 64'd0);
        write_register(ADDR_TEXT_SIZE, 64'd0);
        send_location(FUNC_START, 32'd0, 32'd2, 32'd3, 32'd4, 1'b0);
        send_location(FUNC_START, 32'd1, 32'd2, 32'd3, 32'd4, 1'b0);
        write_register(ADDR_BASE, '1);
        write_register(ADDR_TEXT_SIZE, 64'hFFFF_FFFF);
        send_location(FUNC_START, 32'd0, 32'd5, 32'd6, 32'd7, 1'b1);
        send_location(FUNC_START, 32'd1, 32'd5, 32'd6, 32'd7, 1'b1);
    endtask

    // one well-formed function with random content and the odd broken record
    task automatic run_sequence();
        logic [31:0] off, file, line, col, lim, step;
        int          n;
        lim = cfg_text_size;
        if ({32'd0, lim} > ~cfg_base)
            lim = ~cfg_base[31:0];
        if ($urandom_range(0, 9) == 0)
            off = $urandom_range(0, lim);
        else
            off = $urandom_range(0, (lim < 4096) ? lim : 4096);
        file = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 8);
        line = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 2000);
        col  = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 150);
        send_location(FUNC_START, off, file, line, col, 1'($urandom_range(0, 1)));
        n = $urandom_range(1, 8);
        repeat (n) begin
            step = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 200);
            if (step == 0)
                step = 1;
            if ($urandom_range(0, 99) < 8) begin
                // broken record: offset not past the last one, or no file
                if ($urandom_range(0, 1))
                    send_location(FUNC_NEXT, off - $urandom_range(0, off), file, line, col,
                                  1'($urandom_range(0, 1)));
                else
                    send_location(FUNC_NEXT, off + 1, 32'd0, line, col,
                                  1'($urandom_range(0, 1)));
            end else if (off <= 32'hFFFF_FFFF - step) begin
                off += step;
                if ($urandom_range(0, 3) == 0)
                    file = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 8);
                case ($urandom_range(0, 9))
                    0:       line = $urandom;
                    1, 2:    ;
                    default: line = line + $urandom_range(0, 140) - 70;
                endcase
                if ($urandom_range(0, 2) == 0)
                    col = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 150);
                send_location(FUNC_NEXT, off, file, line, col, 1'($urandom_range(0, 1)));
            end
        end
        // closing record, ignored fields random
        if ($urandom_range(0, 9) == 0)
            off = off - $urandom_range(0, off);
        else
            off = off + $urandom_range(1, 300);
        send_location(FUNC_END, off, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
    endtask

    // random functions mixed with random records under one register setting
    task automatic test_random_programs(input logic [63:0] base, input logic [31:0] limit,
                                        input int count, input int idle);
        int target;
        write_register(ADDR_BASE, base);
        write_register(ADDR_TEXT_SIZE, {32'd0, limit});
        idle_pct = idle;
        target   = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(0, 99) < 15)
                send_location(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                              $urandom, 1'($urandom_range(0, 1)));
            else
                run_sequence();
        end
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_func = FUNC_START;
        s_code_offset = '0;
        s_file_number = '0;
        s_line_number = '0;
        s_column_number = '0;
        s_is_statement = 1'b0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatch_count = 0;
        items_sent = 0;
        cycle_count = 0;
        idle_pct = 22;
        cfg_base = '0;
        cfg_text_size = '1;
        seq_offset = '0;
        seq_file = '0;
        seq_line = '0;
        seq_column = '0;
        seq_stmt = 1'b1;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_without_start();
        test_sequence_basics();
        test_field_extremes();
        test_rejections();
        test_address_limits();
        // first stretch runs with neither side idling
        test_random_programs(64'd0, '1, 80, 0);
        test_random_programs({$urandom, $urandom}, $urandom, 150, 22);
        test_random_programs({32'd0, $urandom}, $urandom_range(0, 5000), 110, 22);
        test_random_programs(64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 100000), '1, 90, 22);

        drain_program();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/lnpe_pkg.sv
src/lnpe_regs.sv
src/lnpe_datapath.sv
src/lnpe_ctrl.sv
src/line_number_program_encoder.sv
src/lnpe_checker.sv
bench/tb_line_number_program_encoder.sv
